/* hw/rtl/pkfi_pkg.sv */
// Package for the plane key find-or-insert core: sizes, key type, op codes
// and the control word that the core broadcasts to its entry cells.
// No dependencies.
`default_nettype none

package pkfi_pkg;

  // Table size
  localparam int MAX_ENTRIES = 128;

  // Field widths
  localparam int HEIGHT_W = 32;
  localparam int TEX_W    = 12;
  localparam int LIGHT_W  = 8;
  localparam int OUT_IDX_W = 7;

  // Match encoder: groups of cells, first hit per group, then first group
  localparam int GRP_SIZE   = 16;
  localparam int GRP_W      = 4;
  localparam int NUM_GRP    = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_IDX_W  = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int PAD_W      = NUM_GRP * GRP_SIZE;
  localparam int FULL_IDX_W = GRP_IDX_W + GRP_W;

  // Fill count holds 0 .. MAX_ENTRIES
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Common width to build the reported index from
  localparam int WIDE_A = (CNT_W > FULL_IDX_W) ? CNT_W : FULL_IDX_W;
  localparam int WIDE_W = (WIDE_A > OUT_IDX_W) ? WIDE_A : OUT_IDX_W;

  // Op codes
  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [TEX_W-1:0]    tex;
    logic [LIGHT_W-1:0]  light;
  } key_t;

  // Broadcast to every cell in the commit cycle
  typedef struct packed {
    logic clear;
    logic insert;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/pkfi_intf.sv */
// Channel interfaces of the plane key find-or-insert core: input words,
// result words and the configuration write channel. Uses pkfi_pkg.
`default_nettype none

interface pkfi_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [pkfi_pkg::HEIGHT_W-1:0] plane_height;
  logic [pkfi_pkg::TEX_W-1:0]        texture_id;
  logic [pkfi_pkg::LIGHT_W-1:0]      light_level;

  modport source (output valid, op, plane_height, texture_id, light_level,
                  input ready);
  modport sink (input valid, op, plane_height, texture_id, light_level,
                output ready);
endinterface

interface pkfi_out_if;
  logic                          valid;
  logic                          ready;
  logic [pkfi_pkg::OUT_IDX_W-1:0] entry_index;
  logic                          is_new;
  logic                          table_full;

  modport source (output valid, entry_index, is_new, table_full, input ready);
  modport sink (input valid, entry_index, is_new, table_full, output ready);
endinterface

interface pkfi_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pkfi_pkg::TEX_W-1:0] sky_texture_id;

  modport source (output valid, sky_texture_id, input ready);
  modport sink (input valid, sky_texture_id, output ready);
endinterface

`default_nettype wire

/* hw/rtl/plane_key_find_or_insert_core.sv */
// Top level of the plane key find-or-insert core: row of entry cells,
// first-match encoder, sequencer and result register.
// Uses pkfi_pkg, pkfi_intf, pkfi_cell and pkfi_match_enc.
//
//   channel  | dir | fields
//   in_if    | in  | op, plane_height, texture_id, light_level
//   out_if   | out | entry_index, is_new, table_full
//   cfg_if   | in  | sky_texture_id (always ready)
//
// A word is taken in the idle state and its result word is registered after
// the parallel compare registered in the cells, the per-group encoder register,
// and the final pick and commit into the result register. One word is in
// work at a time. A result waiting on out_if holds only the commit step; a new
// word is taken once the previous one has committed. Synchronous active-low
// reset empties the table and sets the sky texture to 0; no clearing pass.
`default_nettype none

module plane_key_find_or_insert_core (
  input  logic             clk,
  input  logic             rst_n,
  pkfi_in_if.sink          in_if,
  pkfi_out_if.source       out_if,
  pkfi_cfg_if.sink         cfg_if
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRP,
    ST_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pkfi_pkg::TEX_W-1:0]      sky_r;
  pkfi_pkg::key_t                  key_r;
  logic                            op_r;
  logic [pkfi_pkg::CNT_W-1:0]      used_cnt_r;
  logic                            out_valid_r;
  logic [pkfi_pkg::OUT_IDX_W-1:0]  out_idx_r;
  logic                            out_new_r;
  logic                            out_full_r;

  pkfi_pkg::cell_ctl_t             ctl;
  logic [pkfi_pkg::MAX_ENTRIES-1:0] occ;
  logic [pkfi_pkg::MAX_ENTRIES-1:0] match;
  logic                            enc_hit;
  logic [pkfi_pkg::FULL_IDX_W-1:0] enc_idx;
  logic                            slot_free;
  logic                            commit;
  logic                            tbl_full;
  logic                            is_sky;
  logic [pkfi_pkg::WIDE_W-1:0]     hit_wide;
  logic [pkfi_pkg::WIDE_W-1:0]     cnt_wide;

  // Configuration write
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sky_r <= '0;
    end else if (cfg_if.valid) begin
      sky_r <= cfg_if.sky_texture_id;
    end
  end

  // Row of entry cells
  for (genvar i = 0; i < pkfi_pkg::MAX_ENTRIES; i++) begin : g_cell
    logic prev_occ;
    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_occ = occ[i-1];
    end

    pkfi_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl),
      .key_i      (key_r),
      .prev_occ_i (prev_occ),
      .occ_o      (occ[i]),
      .match_o    (match[i])
    );
  end

  pkfi_match_enc u_enc (
    .clk     (clk),
    .match_i (match),
    .hit_o   (enc_hit),
    .idx_o   (enc_idx)
  );

  // Handshake and commit
  assign in_if.ready = (state_r == ST_IDLE);
  assign slot_free   = !out_valid_r || out_if.ready;
  assign commit      = (state_r == ST_FIN) && slot_free;
  assign tbl_full    = occ[pkfi_pkg::MAX_ENTRIES-1];
  assign is_sky      = (in_if.texture_id == sky_r);
  assign hit_wide    = pkfi_pkg::WIDE_W'(enc_idx);
  assign cnt_wide    = pkfi_pkg::WIDE_W'(used_cnt_r);

  // Cell control in the commit cycle
  always_comb begin
    ctl.clear  = commit && (op_r == pkfi_pkg::OP_CLEAR);
    ctl.insert = commit && (op_r == pkfi_pkg::OP_FIND) && !enc_hit && !tbl_full;
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_if.valid) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_GRP;
      ST_GRP:  state_nxt = ST_FIN;
      ST_FIN:  if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, fill count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        out_idx_r   <= '0;
        out_new_r   <= 1'b0;
        out_full_r  <= 1'b0;
        if (op_r == pkfi_pkg::OP_CLEAR) begin
          used_cnt_r <= '0;
        end else if (enc_hit) begin
          out_idx_r <= hit_wide[pkfi_pkg::OUT_IDX_W-1:0];
        end else if (tbl_full) begin
          out_full_r <= 1'b1;
        end else begin
          out_idx_r  <= cnt_wide[pkfi_pkg::OUT_IDX_W-1:0];
          out_new_r  <= 1'b1;
          used_cnt_r <= used_cnt_r + pkfi_pkg::CNT_W'(1);
        end
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the word; fold sky planes onto one key
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      op_r       <= in_if.op;
      key_r.tex  <= in_if.texture_id;
      key_r.height <= is_sky ? '0 : in_if.plane_height;
      key_r.light  <= is_sky ? '0 : in_if.light_level;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.entry_index = out_idx_r;
  assign out_if.is_new      = out_new_r;
  assign out_if.table_full  = out_full_r;

`ifndef SYNTH
  // Occupancy is a thermometer from cell 0
  a_occ_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ & (occ + pkfi_pkg::MAX_ENTRIES'(1))) == '0))
    else $error("cell occupancy is not contiguous");

  // Fill count tracks the occupied cells
  a_cnt_occ: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(occ) == int'(used_cnt_r)))
    else $error("fill count disagrees with cell occupancy");

  // A clear commit empties every cell
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (occ == '0))
    else $error("table not empty after clear");

  // Insert only into a table with room, never together with a clear
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.insert |-> (!tbl_full && !ctl.clear))
    else $error("insert into full table or during clear");
`endif

endmodule

`default_nettype wire

/* hw/rtl/pkfi_cell.sv */
// One entry cell: stored key, occupancy bit and registered key compare.
// Occupancy is handed down the row so the first free cell takes an insert.
// Uses pkfi_pkg.
`default_nettype none

module pkfi_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  pkfi_pkg::cell_ctl_t ctl_i,
  input  pkfi_pkg::key_t      key_i,
  input  logic                prev_occ_i,
  output logic                occ_o,
  output logic                match_o
);

  logic           occ_r;
  logic           match_r;
  pkfi_pkg::key_t key_r;
  logic           take;

  // First free cell: neighbor above is occupied, this one is not
  assign take = ctl_i.insert && prev_occ_i && !occ_r;

  // Hold occupancy; drop it on clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (ctl_i.clear) begin
      occ_r <= 1'b0;
    end else if (take) begin
      occ_r <= 1'b1;
    end
  end

  // Load key on insert; compare against the broadcast key every cycle
  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= key_i;
    end
    match_r <= occ_r && (key_r == key_i);
  end

  assign occ_o   = occ_r;
  assign match_o = match_r;

endmodule

`default_nettype wire

/* hw/rtl/pkfi_match_enc.sv */
// First-match encoder over the cell row: registered first hit per group of
// cells, then first hitting group. Uses pkfi_pkg.
`default_nettype none

module pkfi_match_enc (
  input  logic                                clk,
  input  logic [pkfi_pkg::MAX_ENTRIES-1:0]    match_i,
  output logic                                hit_o,
  output logic [pkfi_pkg::FULL_IDX_W-1:0]     idx_o
);

  logic [pkfi_pkg::PAD_W-1:0]   pad;
  logic [pkfi_pkg::NUM_GRP-1:0] grp_hit_r;
  logic [pkfi_pkg::GRP_W-1:0]   grp_off_r [pkfi_pkg::NUM_GRP];

  // Pad the match row to whole groups
  always_comb begin
    pad = '0;
    pad[pkfi_pkg::MAX_ENTRIES-1:0] = match_i;
  end

  // First hit inside each group, registered
  for (genvar g = 0; g < pkfi_pkg::NUM_GRP; g++) begin : g_grp
    logic [pkfi_pkg::GRP_SIZE-1:0] bits;
    logic [pkfi_pkg::GRP_W-1:0]    off;

    assign bits = pad[g*pkfi_pkg::GRP_SIZE +: pkfi_pkg::GRP_SIZE];

    always_comb begin
      off = '0;
      for (int b = pkfi_pkg::GRP_SIZE - 1; b >= 0; b--) begin
        if (bits[b]) begin
          off = pkfi_pkg::GRP_W'(b);
        end
      end
    end

    always_ff @(posedge clk) begin
      grp_hit_r[g] <= |bits;
      grp_off_r[g] <= off;
    end
  end

  // Pick the lowest hitting group
  always_comb begin
    logic [pkfi_pkg::GRP_IDX_W-1:0] sel;
    logic [pkfi_pkg::GRP_W-1:0]     off;
    sel   = '0;
    off   = '0;
    hit_o = 1'b0;
    for (int g = pkfi_pkg::NUM_GRP - 1; g >= 0; g--) begin
      if (grp_hit_r[g]) begin
        hit_o = 1'b1;
        sel   = pkfi_pkg::GRP_IDX_W'(g);
        off   = grp_off_r[g];
      end
    end
    idx_o = {sel, off};
  end

endmodule

`default_nettype wire
